[sv/pss_pkg.sv]
package pss_pkg;

	// Field widths
	localparam int COUNT_BITS    = 24;
	localparam int INTERVAL_BITS = 26;
	localparam int CFG_DATA_BITS = 26;
	localparam int CFG_IDX_BITS  = 2;

	localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET = INTERVAL_BITS'(29296);

	// Configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_STEP_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_REVERSE_DIR   = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_HOLD_POWER    = 2'd2;

	// Item action codes
	typedef enum logic [1:0] {
		ACT_TICK = 2'd0,
		ACT_LOAD = 2'd1,
		ACT_STOP = 2'd2
	} action_t;

	typedef struct packed {
		logic [1:0]                   action;
		logic signed [COUNT_BITS-1:0] move_steps;
	} in_item_t;

	typedef struct packed {
		logic [3:0]                   coils;
		logic                         moving;
		logic                         stepped;
		logic signed [COUNT_BITS-1:0] remaining;
	} out_item_t;

	// Full-step coil patterns, A..D from bit 3 to bit 0
	function automatic logic [3:0] phase_pattern(input logic [1:0] phase);
		logic [3:0] pat;
		case (phase)
			2'd0: pat = 4'b1010;
			2'd1: pat = 4'b0110;
			2'd2: pat = 4'b0101;
			2'd3: pat = 4'b1001;
			default: pat = 4'b0000;
		endcase
		return pat;
	endfunction

endpackage

[sv/paced_stepper_sequencer_unit.sv]
// Four-phase full-step stepper pacer.
// Input channel (in_valid/in_ready/in_item): each item is a one-microsecond
// tick, a load of a signed step count, or a stop. Output channel
// (out_valid/out_ready/out_item): exactly one result item per input item,
// giving coil drive, moving flag, stepped flag and the remaining count.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 step interval in us, 1 reverse direction, 2 hold power); write only
// while the block is idle.
// Latency: a result is presented the cycle after its input item is taken.
// Throughput: one item per cycle while the receiver keeps up; the step
// decision (saturating increment, one compare, one count step toward zero
// and the pattern lookup) lies between the state and output registers.
// Stall: in_ready stays high while the output register is empty or being
// drained; when the receiver holds off, the result waits and input stalls.
// Reset (arst_n low): remaining count, elapsed time and phase cleared, coils
// off, interval back to 29296 us, reverse and hold off, no result pending.
module paced_stepper_sequencer_unit
	import pss_pkg::*;
#(
	parameter int TIME_BITS = 26
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  in_item_t                 in_item,
	output logic                     out_valid,
	input  logic                     out_ready,
	output out_item_t                out_item,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	localparam int CMP_W = (TIME_BITS > INTERVAL_BITS) ? TIME_BITS : INTERVAL_BITS;

	// Configuration registers
	logic [INTERVAL_BITS-1:0] interval_q;
	logic                     reverse_q;
	logic                     hold_q;

	// Sequencer state
	logic signed [COUNT_BITS-1:0] remaining_q;
	logic [TIME_BITS-1:0]         elapsed_q;
	logic [1:0]                   phase_q;
	logic [3:0]                   coils_q;

	logic      out_valid_q;
	out_item_t out_item_q;

	logic                         accept;
	logic [TIME_BITS-1:0]         elapsed_inc;
	logic                         rem_nz, rem_pos, step_due, dir_down;
	logic [1:0]                   phase_step;
	logic signed [COUNT_BITS-1:0] rem_step;
	logic signed [COUNT_BITS-1:0] remaining_d;
	logic [TIME_BITS-1:0]         elapsed_d;
	logic [1:0]                   phase_d;
	logic [3:0]                   coils_d;
	logic                         stepped_d;

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// Step decision for a tick
	assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + TIME_BITS'(1);
	assign rem_nz      = (remaining_q != '0);
	assign rem_pos     = rem_nz && !remaining_q[COUNT_BITS-1];
	assign step_due    = rem_nz && (CMP_W'(elapsed_inc) >= CMP_W'(interval_q));
	assign dir_down    = rem_pos ^ reverse_q;
	assign phase_step  = dir_down ? phase_q - 2'd1 : phase_q + 2'd1;
	assign rem_step    = rem_pos ? remaining_q - COUNT_BITS'(1)
	                             : remaining_q + COUNT_BITS'(1);

	// Next state per action
	always_comb begin
		remaining_d = remaining_q;
		elapsed_d   = elapsed_q;
		phase_d     = phase_q;
		coils_d     = coils_q;
		stepped_d   = 1'b0;
		case (in_item.action)
			ACT_TICK: begin
				elapsed_d = elapsed_inc;
				if (step_due) begin
					phase_d     = phase_step;
					remaining_d = rem_step;
					elapsed_d   = '0;
					stepped_d   = 1'b1;
					if (rem_step == '0 && !hold_q)
						coils_d = 4'b0000;
					else
						coils_d = phase_pattern(phase_step);
				end
			end
			ACT_LOAD: begin
				remaining_d = in_item.move_steps;
			end
			ACT_STOP: begin
				remaining_d = '0;
				if (!hold_q)
					coils_d = 4'b0000;
			end
			default: begin
			end
		endcase
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RESET;
			reverse_q  <= 1'b0;
			hold_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STEP_INTERVAL: interval_q <= cfg_data[INTERVAL_BITS-1:0];
				REG_REVERSE_DIR:   reverse_q  <= cfg_data[0];
				REG_HOLD_POWER:    hold_q     <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// State update on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remaining_q <= '0;
			elapsed_q   <= '0;
			phase_q     <= 2'd0;
			coils_q     <= 4'b0000;
		end else if (accept) begin
			remaining_q <= remaining_d;
			elapsed_q   <= elapsed_d;
			phase_q     <= phase_d;
			coils_q     <= coils_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_item_q.coils     <= coils_d;
			out_item_q.moving    <= (remaining_d != '0);
			out_item_q.stepped   <= stepped_d;
			out_item_q.remaining <= remaining_d;
		end
	end

	// Checks
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("accepted item gave no result");

	a_moving_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.moving == (out_item.remaining != '0)))
		else $error("moving flag disagrees with remaining count");

	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_item.action == ACT_STOP && !hold_q) |=>
			(out_item.coils == 4'b0000 && !out_item.moving))
		else $error("stop left coils on or move running");

	a_step_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.stepped && out_item.moving) |->
			$countones(out_item.coils) == 2)
		else $error("step drove an invalid coil pattern");

endmodule
